// ===== rtl/shtlp_pkg.sv =====
// ----------------------------------------------------------------------------
// shtlp_pkg: shared types and constants of the linear-probe hash table
// Status codes, default sizes, the djb2 start value and the reset value of
// the entry limit.
// ----------------------------------------------------------------------------
package shtlp_pkg;

  localparam int DEF_CAPACITY  = 256;
  localparam int DEF_KEY_BYTES = 63;
  localparam logic [31:0] HASH_START = 32'd5381;
  localparam logic [7:0]  MAX_ENTRIES_RESET = 8'd85;

  typedef enum logic [2:0] {
    ST_FOUND     = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_INSERTED  = 3'd2,
    ST_UPDATED   = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

endpackage

// ===== rtl/shtlp_key_front.sv =====
// ----------------------------------------------------------------------------
// shtlp_key_front: key assembly and hashing
// Collect key bytes, run the djb2 hash, and emit one request per last byte.
// ----------------------------------------------------------------------------
module shtlp_key_front #(
  parameter int KEY_BYTES = shtlp_pkg::DEF_KEY_BYTES
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_take,
  input  logic                   in_kind,
  input  logic [7:0]             in_key_byte,
  input  logic                   in_key_last,
  input  logic [63:0]            in_new_value,
  output logic                   req_valid,
  output logic                   req_kind,
  output logic [KEY_BYTES*8-1:0] req_key,
  output logic [31:0]            req_hash,
  output logic [63:0]            req_value
);
  import shtlp_pkg::*;

  localparam int LW = $clog2(KEY_BYTES + 1);

  logic [KEY_BYTES*8-1:0] key_r, key_nxt;
  logic [LW-1:0]          len_r, len_nxt;
  logic [31:0]            hash_r, hash_nxt;
  logic                   ended_r, ended_nxt;

  always_comb begin
    key_nxt   = key_r;
    len_nxt   = len_r;
    hash_nxt  = hash_r;
    ended_nxt = ended_r;
    if (!ended_r) begin
      if (in_key_byte == 8'd0) begin
        ended_nxt = 1'b1;
      end else if (len_r < LW'(KEY_BYTES)) begin
        key_nxt[len_r*8 +: 8] = in_key_byte;
        len_nxt  = len_r + LW'(1);
        hash_nxt = (hash_r << 5) + hash_r + {24'd0, in_key_byte};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r     <= '0;
      len_r     <= '0;
      hash_r    <= HASH_START;
      ended_r   <= 1'b0;
      req_valid <= 1'b0;
    end else begin
      req_valid <= in_take && in_key_last;
      if (in_take) begin
        if (in_key_last) begin
          key_r   <= '0;
          len_r   <= '0;
          hash_r  <= HASH_START;
          ended_r <= 1'b0;
        end else begin
          key_r   <= key_nxt;
          len_r   <= len_nxt;
          hash_r  <= hash_nxt;
          ended_r <= ended_nxt;
        end
      end
    end
  end

  // request payload, held until the next last byte
  always_ff @(posedge clk) begin
    if (in_take && in_key_last) begin
      req_kind  <= in_kind;
      req_key   <= key_nxt;
      req_hash  <= hash_nxt;
      req_value <= in_new_value;
    end
  end

endmodule

// ===== rtl/shtlp_probe_engine.sv =====
// ----------------------------------------------------------------------------
// shtlp_probe_engine: linear probe over the slot memory
// Read one slot per step, compare the stored key, then answer and update.
// ----------------------------------------------------------------------------
module shtlp_probe_engine #(
  parameter int CAPACITY  = shtlp_pkg::DEF_CAPACITY,
  parameter int KEY_BYTES = shtlp_pkg::DEF_KEY_BYTES
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [7:0]             max_entries,
  input  logic                   req_valid,
  input  logic                   req_kind,
  input  logic [KEY_BYTES*8-1:0] req_key,
  input  logic [31:0]            req_hash,
  input  logic [63:0]            req_value,
  output logic                   busy,
  output logic                   res_valid,
  output logic [2:0]             res_status,
  output logic [63:0]            res_value
);
  import shtlp_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_CHECK, S_CLEAR} state_t;

  logic [KEY_BYTES*8-1:0] keys_mem [CAPACITY];
  logic [63:0]            vals_mem [CAPACITY];
  logic [CAPACITY-1:0]    occ_r;
  logic [KEY_BYTES*8-1:0] rd_key_r;
  logic [63:0]            rd_val_r;
  state_t                 state_r;
  logic [AW-1:0]          slot_r;
  logic [CW-1:0]          steps_r;
  logic [8:0]             count_r;
  logic                   wr_key, wr_val;
  logic                   hit;
  logic                   done;
  status_t                done_status;
  logic [63:0]            done_value;

  assign busy = (state_r != S_IDLE);
  assign hit  = (rd_key_r == req_key);

  always_comb begin
    wr_key = 1'b0;
    wr_val = 1'b0;
    if (state_r == S_CHECK && req_kind) begin
      if (!occ_r[slot_r]) begin
        wr_key = ({1'b0, count_r} < {2'b0, max_entries});
        wr_val = wr_key;
      end else if (hit) begin
        wr_val = 1'b1;
      end
    end
  end

  // classify the slot under check: free, matching, or last step of a full wrap
  always_comb begin
    done        = 1'b0;
    done_status = ST_FULL;
    done_value  = 64'd0;
    if (state_r == S_CHECK) begin
      if (!occ_r[slot_r]) begin
        done = 1'b1;
        if (!req_kind) begin
          done_status = ST_NOT_FOUND;
        end else if (wr_key) begin
          done_status = ST_INSERTED;
        end else begin
          done_status = ST_FULL;
        end
      end else if (hit) begin
        done = 1'b1;
        if (!req_kind) begin
          done_status = ST_FOUND;
          done_value  = rd_val_r;
        end else begin
          done_status = ST_UPDATED;
        end
      end else if (steps_r == CW'(CAPACITY - 1)) begin
        done        = 1'b1;
        done_status = ST_FULL;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_key_r <= keys_mem[slot_r];
    rd_val_r <= vals_mem[slot_r];
    if (wr_key) keys_mem[slot_r] <= req_key;
    if (wr_val) vals_mem[slot_r] <= req_value;
  end

  always_ff @(posedge clk) begin
    if (done) begin
      res_status <= done_status;
      res_value  <= done_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      occ_r     <= '0;
      count_r   <= '0;
      slot_r    <= '0;
      steps_r   <= '0;
      res_valid <= 1'b0;
    end else begin
      res_valid <= done;
      case (state_r)
        S_IDLE: begin
          if (req_valid) begin
            slot_r  <= req_hash[AW-1:0];
            steps_r <= '0;
            state_r <= S_READ;
          end
        end
        S_READ: state_r <= S_CHECK;  // wait for registered read data
        S_CHECK: begin
          if (done) begin
            state_r <= S_IDLE;
            if (wr_key) begin
              occ_r[slot_r] <= 1'b1;
              count_r       <= count_r + 9'd1;
            end
          end else begin
            slot_r  <= slot_r + AW'(1);
            steps_r <= steps_r + CW'(1);
            state_r <= S_READ;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/shtlp_result_fifo.sv =====
// ----------------------------------------------------------------------------
// shtlp_result_fifo: two-entry result queue
// Hold finished results until the consumer pops them.
// ----------------------------------------------------------------------------
module shtlp_result_fifo (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  logic [2:0]  wr_status,
  input  logic [63:0] wr_value,
  input  logic        rd_en,
  output logic        empty,
  output logic        room,
  output logic [2:0]  rd_status,
  output logic [63:0] rd_value
);
  logic [66:0] buf_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;

  assign empty     = (cnt_r == 2'd0);
  assign room      = (cnt_r != 2'd2);
  assign rd_status = buf_r[rp_r][66:64];
  assign rd_value  = buf_r[rp_r][63:0];

  always_ff @(posedge clk) begin
    if (wr_en) buf_r[wp_r] <= {wr_status, wr_value};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

endmodule

// ===== rtl/symbol_hash_table_linear_probe_unit.sv =====
// ----------------------------------------------------------------------------
// symbol_hash_table_linear_probe_unit: key/value store, linear probing
// Channel   | Direction | Beat
// in_*      | input     | kind, key_byte, key_last, new_value (push/full)
// out_*     | output    | status, read_value (pop/empty)
// cfg_*     | input     | max_entries write (cfg_we/cfg_data)
// A non-last byte is accepted whenever full is low. A last byte starts a probe
// of the slots; each probe is one read of the single-port slot memory
// followed by a key compare, and the result shows once the probe ends.
// full is high while a request is handed on or probes, while a result is written,
// or while both result slots are taken. Reset clears slot occupancy flags at once;
// no clearing pass.
module symbol_hash_table_linear_probe_unit #(
  parameter int CAPACITY  = shtlp_pkg::DEF_CAPACITY,
  parameter int KEY_BYTES = shtlp_pkg::DEF_KEY_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic        in_kind,
  input  logic [7:0]  in_key_byte,
  input  logic        in_key_last,
  input  logic [63:0] in_new_value,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_status,
  output logic [63:0] out_read_value,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data
);
  import shtlp_pkg::*;

  logic [7:0]             max_r;
  logic                   take, req_valid, req_kind, busy, room;
  logic [KEY_BYTES*8-1:0] req_key;
  logic [31:0]            req_hash;
  logic [63:0]            req_value, res_value;
  logic                   res_valid;
  logic [2:0]             res_status;

  // hold the limit register
  always_ff @(posedge clk) begin
    if (!rst_n) max_r <= MAX_ENTRIES_RESET;
    else if (cfg_we) max_r <= cfg_data;
  end

  // stall while a request is in flight or the result queue has no free slot
  assign full = busy || req_valid || res_valid || !room;
  assign take = push && !full;

  shtlp_key_front #(.KEY_BYTES(KEY_BYTES)) u_front (
    .clk, .rst_n, .in_take(take), .in_kind, .in_key_byte, .in_key_last,
    .in_new_value, .req_valid, .req_kind, .req_key, .req_hash, .req_value
  );

  shtlp_probe_engine #(.CAPACITY(CAPACITY), .KEY_BYTES(KEY_BYTES)) u_probe (
    .clk, .rst_n, .max_entries(max_r), .req_valid, .req_kind, .req_key,
    .req_hash, .req_value, .busy, .res_valid, .res_status, .res_value
  );

  shtlp_result_fifo u_fifo (
    .clk, .rst_n, .wr_en(res_valid), .wr_status(res_status),
    .wr_value(res_value), .rd_en(pop && !empty), .empty, .room,
    .rd_status(out_status), .rd_value(out_read_value)
  );

`ifndef SYNTHESIS
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !take) else $error("beat taken while probing");
  a_req_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req_valid |-> !busy) else $error("request while engine busy");
  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> room) else $error("result with no room");
`endif

endmodule
